// ===== design/hsrp_pkg.sv =====
// ----------------------------------------------------------------------------
// hsrp_pkg
// Shared types and constants for the HID sample ring producer core.
// ----------------------------------------------------------------------------
package hsrp_pkg;

  // Default ring depth; the core takes it as a parameter
  localparam int unsigned RingDepthDef = 8;

  // Button word layout
  localparam logic [31:0] ButtonMask = 32'h0000_3fff;
  localparam logic [31:0] DirRight   = 32'h1000_0000;
  localparam logic [31:0] DirLeft    = 32'h2000_0000;
  localparam logic [31:0] DirUp      = 32'h4000_0000;
  localparam logic [31:0] DirDown    = 32'h8000_0000;

  // Width of the slot field in a result
  localparam int unsigned SlotOutW = 3;

  // One input sample, last field in the lowest bits
  typedef struct packed {
    logic [63:0]        sample_tick;
    logic               touch_pressed;
    logic [15:0]        touch_y;
    logic [15:0]        touch_x;
    logic signed [15:0] circle_y;
    logic signed [15:0] circle_x;
    logic [31:0]        raw_buttons;
  } sample_t;

  // One ring entry result, last field in the lowest bits
  typedef struct packed {
    logic [63:0]         previous_reset_tick;
    logic [63:0]         reset_tick;
    logic                tick_updated;
    logic                touch_pressed_out;
    logic [15:0]         touch_y_out;
    logic [15:0]         touch_x_out;
    logic signed [15:0]  pad_y_out;
    logic signed [15:0]  pad_x_out;
    logic [31:0]         removals;
    logic [31:0]         additions;
    logic [31:0]         buttons;
    logic [SlotOutW-1:0] ring_slot;
  } entry_t;

  localparam int unsigned SampleW   = $bits(sample_t);
  localparam int unsigned EntryW    = $bits(entry_t);
  localparam int unsigned InDataW   = ((SampleW + 7) / 8) * 8;
  localparam int unsigned OutDataW  = ((EntryW + 7) / 8) * 8;

  // Direction bits for one pad axis from its sign
  function automatic logic [31:0] axis_bits(logic signed [15:0] axis,
                                            logic [31:0] pos_bit,
                                            logic [31:0] neg_bit);
    logic [31:0] res;
    res = '0;
    if (axis != 16'sd0) begin
      res = axis[15] ? neg_bit : pos_bit;
    end
    return res;
  endfunction

endpackage

// ===== design/hid_sample_ring_producer_core.sv =====
// ----------------------------------------------------------------------------
// hid_sample_ring_producer_core
// Turns HID samples into pad/touch ring entries with button edge reports.
// ----------------------------------------------------------------------------
// Takes one sample per cycle unless the output stalls, and returns one ring
// entry per sample in the cycle after the transfer, from a single result
// register; the sample is accepted whenever that register is empty or being
// drained in the same cycle. Buttons are masked to 14 bits, bits 28..31 carry
// the circle pad directions, and additions/removals are taken against the
// previous sample's button word. The write slot counts modulo RING_DEPTH; on
// slot 0 the sample tick becomes the reset tick and the old one moves to
// previous_reset_tick. ring_slot carries the low three bits of the slot. There
// is no startup sweep: the block is ready right after reset.
module hid_sample_ring_producer_core
  import hsrp_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RingDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // tdata: raw_buttons[31:0], circle_x[47:32], circle_y[63:48],
  //        touch_x[79:64], touch_y[95:80], touch_pressed[96],
  //        sample_tick[160:97], zero pad above
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // tdata: ring_slot[2:0], buttons[34:3], additions[66:35],
  //        removals[98:67], pad_x_out[114:99], pad_y_out[130:115],
  //        touch_x_out[146:131], touch_y_out[162:147],
  //        touch_pressed_out[163], tick_updated[164],
  //        reset_tick[228:165], previous_reset_tick[292:229], zero pad above
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned SlotW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [SlotW-1:0] SlotLast = SlotW'(RING_DEPTH - 1);

  sample_t           sample;
  entry_t            entry_d, entry_q;
  logic              out_valid_q;
  logic              in_xfer;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [31:0]       last_btn_q;
  logic [63:0]       reset_tick_q, reset_tick_d;
  logic [63:0]       prev_tick_q, prev_tick_d;
  logic [31:0]       btn;
  logic              wrap;
  logic [SlotW+SlotOutW-1:0] slot_ext;

  assign sample          = sample_t'(s_axis_tdata_i[SampleW-1:0]);
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // Button word, slot and tick bookkeeping for the incoming sample
  always_comb begin
    btn = (sample.raw_buttons & ButtonMask)
        | axis_bits(sample.circle_x, DirRight, DirLeft)
        | axis_bits(sample.circle_y, DirUp, DirDown);
    wrap         = (slot_q == '0);
    slot_d       = (slot_q == SlotLast) ? '0 : slot_q + SlotW'(1);
    reset_tick_d = wrap ? sample.sample_tick : reset_tick_q;
    prev_tick_d  = wrap ? reset_tick_q : prev_tick_q;
    slot_ext     = {{SlotOutW{1'b0}}, slot_q};

    entry_d.ring_slot           = slot_ext[SlotOutW-1:0];
    entry_d.buttons             = btn;
    entry_d.additions           = btn & ~last_btn_q;
    entry_d.removals            = last_btn_q & ~btn;
    entry_d.pad_x_out           = sample.circle_x;
    entry_d.pad_y_out           = sample.circle_y;
    entry_d.touch_x_out         = sample.touch_x;
    entry_d.touch_y_out         = sample.touch_y;
    entry_d.touch_pressed_out   = sample.touch_pressed;
    entry_d.tick_updated        = wrap;
    entry_d.reset_tick          = reset_tick_d;
    entry_d.previous_reset_tick = prev_tick_d;
  end

  // Ring state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q       <= '0;
      last_btn_q   <= '0;
      reset_tick_q <= '0;
      prev_tick_q  <= '0;
    end else if (in_xfer) begin
      slot_q       <= slot_d;
      last_btn_q   <= btn;
      reset_tick_q <= reset_tick_d;
      prev_tick_q  <= prev_tick_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      entry_q <= entry_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - EntryW){1'b0}}, entry_q};

  // A bit cannot be added and removed in the same entry
  a_add_rem_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((entry_q.additions & entry_q.removals) == 32'h0))
    else $error("additions and removals overlap");

  // Tick update happens only on slot zero
  a_tick_on_slot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && entry_q.tick_updated) |-> (entry_q.ring_slot == '0))
    else $error("tick update outside slot zero");

  // The slot counter wraps after its last value
  a_slot_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && slot_q == SlotLast) |=> (slot_q == '0))
    else $error("slot counter did not wrap");

  // Entry tick fields mirror the held state after each transfer
  a_tick_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (entry_q.reset_tick == reset_tick_q &&
                 entry_q.previous_reset_tick == prev_tick_q))
    else $error("entry ticks disagree with held ticks");

  // An empty result register never stalls the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hid_sample_ring_producer_core: drives HID samples
// over the input stream and checks each ring entry against a predictor.
// ----------------------------------------------------------------------------
// A scoreboard object keeps its own slot counter, button history and reset
// ticks, predicts one entry per accepted sample and checks the entries in
// order as they leave the block. Both stream sides idle at random; one phase
// holds the output off for a long stretch so that the input backs up.
module tb
  import hsrp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RingDepth  = RingDepthDef;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 80;

  // Predicts ring entries and checks the ones leaving the block
  class ring_entry_board;
    entry_t      expected_q[$];
    int unsigned ring_depth;
    int unsigned next_slot;
    logic [31:0] prev_buttons;
    logic [63:0] cur_reset_tick;
    logic [63:0] old_reset_tick;
    int unsigned mismatches;

    function new(int unsigned depth);
      ring_depth     = depth;
      next_slot      = 0;
      prev_buttons   = '0;
      cur_reset_tick = '0;
      old_reset_tick = '0;
      mismatches     = 0;
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    // Work out the entry for one accepted sample and advance the state
    function void note_sample(sample_t s);
      entry_t      e;
      logic [31:0] btn;
      int unsigned slot;
      slot = next_slot % ring_depth;
      btn  = s.raw_buttons & ButtonMask;
      if ($signed(s.circle_x) > 16'sd0) btn |= DirRight;
      else if ($signed(s.circle_x) < 16'sd0) btn |= DirLeft;
      if ($signed(s.circle_y) > 16'sd0) btn |= DirUp;
      else if ($signed(s.circle_y) < 16'sd0) btn |= DirDown;
      e.tick_updated = 1'b0;
      if (slot == 0) begin
        old_reset_tick = cur_reset_tick;
        cur_reset_tick = s.sample_tick;
        e.tick_updated = 1'b1;
      end
      e.ring_slot           = slot[SlotOutW-1:0];
      e.buttons             = btn;
      e.additions           = btn & ~prev_buttons;
      e.removals            = prev_buttons & ~btn;
      e.pad_x_out           = s.circle_x;
      e.pad_y_out           = s.circle_y;
      e.touch_x_out         = s.touch_x;
      e.touch_y_out         = s.touch_y;
      e.touch_pressed_out   = s.touch_pressed;
      e.reset_tick          = cur_reset_tick;
      e.previous_reset_tick = old_reset_tick;
      prev_buttons = btn;
      next_slot    = (slot + 1) % ring_depth;
      expected_q.push_back(e);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("%s got %h want %h", name, got, want));
      end
    endtask

    // Compare one outgoing entry with the oldest prediction
    task check_entry(entry_t got);
      entry_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("entry with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      compare_field("ring_slot", 64'(got.ring_slot), 64'(want.ring_slot));
      compare_field("buttons", 64'(got.buttons), 64'(want.buttons));
      compare_field("additions", 64'(got.additions), 64'(want.additions));
      compare_field("removals", 64'(got.removals), 64'(want.removals));
      compare_field("pad_x_out", 64'(unsigned'(got.pad_x_out)),
                    64'(unsigned'(want.pad_x_out)));
      compare_field("pad_y_out", 64'(unsigned'(got.pad_y_out)),
                    64'(unsigned'(want.pad_y_out)));
      compare_field("touch_x_out", 64'(got.touch_x_out), 64'(want.touch_x_out));
      compare_field("touch_y_out", 64'(got.touch_y_out), 64'(want.touch_y_out));
      compare_field("touch_pressed_out", 64'(got.touch_pressed_out),
                    64'(want.touch_pressed_out));
      compare_field("tick_updated", 64'(got.tick_updated), 64'(want.tick_updated));
      compare_field("reset_tick", got.reset_tick, want.reset_tick);
      compare_field("previous_reset_tick", got.previous_reset_tick,
                    want.previous_reset_tick);
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;

  ring_entry_board board;
  int unsigned     cycle_count;
  bit              no_idle;
  bit              rx_long_hold;
  logic [31:0]     last_raw;
  logic [63:0]     tick_base;

  hid_sample_ring_producer_core #(
    .RING_DEPTH(RingDepth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Transfer monitor: check outgoing entries, note accepted samples
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      board.check_entry(m_axis_tdata_o[EntryW-1:0]);
    end
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      board.note_sample(s_axis_tdata_i[SampleW-1:0]);
    end
  end

  // Idle cycles before the next transfer; mostly short, sometimes long
  function automatic int unsigned pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 18);
    return $urandom_range(0, 2);
  endfunction

  function automatic sample_t mk(logic [31:0] raw, logic [15:0] cx, logic [15:0] cy,
                                 logic [15:0] tx, logic [15:0] ty, logic tp,
                                 logic [63:0] tick);
    sample_t s;
    s.raw_buttons   = raw;
    s.circle_x      = cx;
    s.circle_y      = cy;
    s.touch_x       = tx;
    s.touch_y       = ty;
    s.touch_pressed = tp;
    s.sample_tick   = tick;
    return s;
  endfunction

  // Axis value that hits zero and the extremes often
  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 7))
      0, 1:    return 16'h0000;
      2:       return 16'h7fff;
      3:       return 16'h8000;
      4:       return 16'(($urandom_range(0, 1) == 0) ? 1 : -1);
      default: return 16'($urandom);
    endcase
  endfunction

  // Random sample: low button bits usually one flip away from the last ones
  function automatic sample_t rand_sample();
    logic [31:0] raw;
    logic [63:0] tick;
    if ($urandom_range(0, 3) == 0) raw = $urandom;
    else raw = last_raw ^ (32'h1 << $urandom_range(0, 15)) ^ ($urandom & 32'hffffc000);
    last_raw = raw;
    if ($urandom_range(0, 7) == 0) tick = {$urandom, $urandom};
    else tick = tick_base + 64'($urandom_range(1, 5000));
    tick_base = tick;
    return mk(raw, pick_axis(), pick_axis(), 16'($urandom), 16'($urandom),
              1'($urandom), tick);
  endfunction

  // Offer one sample after a random gap, return once it is accepted
  task automatic send_sample(sample_t s);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i  <= {{(InDataW - SampleW){1'b0}}, s};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_sample(rand_sample());
  endtask

  // Stop offering and wait until every entry has come out
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  // Output side: random holds per entry, one long hold on request
  initial begin
    int unsigned w;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_long_hold) begin
        @(negedge clk_i);
        m_axis_tready_i <= 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
        rx_long_hold = 1'b0;
      end else begin
        w = pick_gap();
        if (w > 0) begin
          @(negedge clk_i);
          m_axis_tready_i <= 1'b0;
          repeat (w - 1) @(negedge clk_i);
        end
      end
      @(negedge clk_i);
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Stimulus
  initial begin
    board           = new(RingDepth);
    no_idle         = 1'b0;
    rx_long_hold    = 1'b0;
    last_raw        = '0;
    tick_base       = 64'd1000;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, zero axes, ignored button bits, slot wraps
    send_sample(mk(32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h0));
    send_sample(mk(32'hffff_ffff, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff, 1'b1,
                   64'hffff_ffff_ffff_ffff));
    send_sample(mk(32'h0, 16'h8000, 16'h8000, 16'h0, 16'h0, 1'b0, 64'h0));
    send_sample(mk(32'h0000_3fff, 16'h0001, 16'hffff, 16'h1234, 16'h8000, 1'b1,
                   64'h1));
    send_sample(mk(32'hffff_c000, 16'hffff, 16'h0001, 16'h7fff, 16'h0001, 1'b0,
                   64'h2));
    send_sample(mk(32'h0000_2aaa, 16'h0, 16'h7fff, 16'haaaa, 16'h5555, 1'b1, 64'h3));
    send_sample(mk(32'h5555_1555, 16'h8000, 16'h0, 16'h5555, 16'haaaa, 1'b0, 64'h4));
    send_sample(mk(32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h5));
    // second pass through slot zero
    send_sample(mk(32'h0000_0001, 16'h0, 16'h0, 16'hffff, 16'h0, 1'b1,
                   64'h8000_0000_0000_0000));
    send_sample(mk(32'hffff_ffff, 16'h8000, 16'h7fff, 16'h0, 16'hffff, 1'b0,
                   64'h7fff_ffff_ffff_ffff));
    send_sample(mk(32'h0, 16'h7fff, 16'h8000, 16'h0, 16'h0, 1'b0, 64'h0));
    send_sample(mk(32'h0000_2000, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1, 64'h0));
    send_sample(mk(32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h0));
    send_sample(mk(32'h0000_3fff, 16'hffff, 16'hffff, 16'h1, 16'h1, 1'b1, 64'h0));
    send_sample(mk(32'h0, 16'h1, 16'h1, 16'h2, 16'h2, 1'b0, 64'h0));
    send_sample(mk(32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h0));
    // third pass through slot zero with all-ones tick
    send_sample(mk(32'hffff_ffff, 16'h0, 16'h0, 16'hffff, 16'hffff, 1'b1,
                   64'hffff_ffff_ffff_ffff));
    send_sample(mk(32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 64'h0));
    drain();

    // Long output hold while samples keep coming back to back
    rx_long_hold = 1'b1;
    no_idle      = 1'b1;
    send_random(30);
    no_idle      = 1'b0;

    send_random(150);
    drain();

    // Back to back on both sides
    no_idle = 1'b1;
    send_random(100);
    no_idle = 1'b0;

    send_random(170);
    drain();

    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/hsrp_pkg.sv
design/hid_sample_ring_producer_core.sv
tb/sv/tb.sv
